### sv/iis_pkg.sv
package iis_pkg;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;

  localparam int PIX_W = 8;
  localparam int SUM_W = 28;
  localparam int CFG_W = 11;
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int RUN_W = PIX_W + COL_W;

  localparam int DIM_A = (CFG_W > COL_W + 1) ? CFG_W : COL_W + 1;
  localparam int DIM_W = (DIM_A > ROW_W + 1) ? DIM_A : ROW_W + 1;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  // Last valid position for a dimension register: zero counts as one and
  // anything above the maximum is held at the maximum.
  function automatic logic [DIM_W-1:0] last_index(input logic [CFG_W-1:0] v,
                                                  input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] ext;
    logic [DIM_W-1:0] r;
    ext = DIM_W'(v);
    if (ext == '0) begin
      r = '0;
    end else if (ext > maxv) begin
      r = maxv - DIM_W'(1);
    end else begin
      r = ext - DIM_W'(1);
    end
    return r;
  endfunction

endpackage

### sv/integral_image_stream.sv
// Streaming integral image. Pixels enter in raster order on the input
// channel (in_valid, in_stall, pixel); each request is accepted at a rising
// edge with in_valid high and in_stall low. For each pixel one result leaves
// on the output channel (out_valid, out_stall, area_sum, frame_end): the sum
// of all pixels of the frame above and left of it, itself included, with
// frame_end set on the last pixel of the frame.
// The frame size comes from two registers written on the configuration port
// (cfg_write, cfg_index, cfg_data); the user must write them only while the
// stream is idle; the block does not enforce it. Both reset to 1024; zero
// counts as one, larger values are held at 1024. Each pixel passes the stage
// and the output register. Throughput is one pixel per cycle unless stalled,
// set by the single read and single write port of the previous-row line store.
// A stage between the line store read and the output register lets the block
// keep accepting while a result waits; when the receiver stalls, both stages
// fill and then in_stall rises until the output is taken.
// Synchronous reset clears the counters, the row sum and both stages; the
// line store is not cleared, since the first row of every frame ignores it.
module integral_image_stream (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic                        cfg_index,
  input  logic [iis_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [iis_pkg::PIX_W-1:0]   pixel,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [iis_pkg::SUM_W-1:0]   area_sum,
  output logic                        frame_end
);
  import iis_pkg::*;

  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;

  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;
  logic [RUN_W-1:0] row_running_sum;
  logic [RUN_W-1:0] run_next;

  logic [DIM_W-1:0] col_last;
  logic [DIM_W-1:0] row_last;
  logic             last_col;
  logic             last_row;

  logic [SUM_W-1:0] line_mem [MAX_COLS];
  logic [SUM_W-1:0] rd_data;
  logic             fwd_hit;
  logic [SUM_W-1:0] fwd_data;

  logic             s1_valid;
  logic [COL_W-1:0] s1_col;
  logic             s1_row_nz;
  logic [RUN_W-1:0] s1_run;
  logic             s1_end;
  logic [SUM_W-1:0] s1_above;
  logic [SUM_W-1:0] s1_sum;

  logic             in_accept;
  logic             s1_advance;

  assign col_last = last_index(frame_width, DIM_W'(MAX_COLS));
  assign row_last = last_index(frame_height, DIM_W'(MAX_ROWS));
  assign last_col = DIM_W'(column_count) >= col_last;
  assign last_row = DIM_W'(row_count) >= row_last;

  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = s1_valid && !s1_advance;
  assign in_accept  = in_valid && !in_stall;

  assign run_next = row_running_sum + RUN_W'(pixel);

  assign s1_above = fwd_hit ? fwd_data : rd_data;
  assign s1_sum   = (s1_row_nz ? s1_above : '0) + SUM_W'(s1_run);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CFG_W'(MAX_COLS);
      frame_height <= CFG_W'(MAX_ROWS);
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count    <= '0;
      row_count       <= '0;
      row_running_sum <= '0;
    end else if (in_accept) begin
      if (last_col) begin
        column_count    <= '0;
        row_running_sum <= '0;
        if (last_row) begin
          row_count <= '0;
        end else begin
          row_count <= row_count + ROW_W'(1);
        end
      end else begin
        column_count    <= column_count + COL_W'(1);
        row_running_sum <= run_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_data <= line_mem[column_count];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      line_mem[s1_col] <= s1_sum;
    end
  end

  // A one-pixel row reads the entry that the previous pixel writes in the
  // same cycle, so that value is passed around the line store.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      fwd_hit   <= s1_advance && (s1_col == column_count);
      fwd_data  <= s1_sum;
      s1_col    <= column_count;
      s1_row_nz <= row_count != '0;
      s1_run    <= run_next;
      s1_end    <= last_col && last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      area_sum  <= s1_sum;
      frame_end <= s1_end;
    end
  end

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !s1_valid)
    else $error("pipeline not empty after reset");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (rst)
    s1_advance |=> out_valid)
    else $error("result lost between stage and output register");

  a_first_row_no_above: assert property (@(posedge clk) disable iff (rst)
    in_accept && (row_count == '0) |=> !s1_row_nz)
    else $error("first row uses line store");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    in_accept && last_col && last_row |=> (row_count == '0) && (column_count == '0))
    else $error("counters did not restart at frame end");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled without a full pipeline");

endmodule

### verif/integral_image_checker.sv
`timescale 1ns / 100ps
module integral_image_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic                      cfg_index,
  input  logic [iis_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [iis_pkg::PIX_W-1:0] pixel,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [iis_pkg::SUM_W-1:0] area_sum,
  input  logic                      frame_end,
  output int unsigned               mismatches,
  output int unsigned               outstanding
);
  import iis_pkg::*;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             last;
  } area_result_t;

  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic [SUM_W-1:0] upper_sums [MAX_COLS];
  logic [RUN_W-1:0] row_sum;
  int unsigned      col_pos;
  int unsigned      row_pos;
  area_result_t     sums_due [$];
  int unsigned      fail_count = 0;

  function automatic int unsigned clip_dim(input logic [CFG_W-1:0] v,
                                           input int unsigned limit);
    if (v == '0) return 1;
    if (v > limit) return limit;
    return 32'(v);
  endfunction

  function automatic area_result_t next_area(input logic [PIX_W-1:0] px);
    int unsigned      last_col;
    int unsigned      last_row;
    logic [SUM_W-1:0] above;
    area_result_t     r;
    last_col = clip_dim(width_reg, MAX_COLS) - 1;
    last_row = clip_dim(height_reg, MAX_ROWS) - 1;
    row_sum = row_sum + RUN_W'(px);
    above = (row_pos != 0) ? upper_sums[COL_W'(col_pos)] : '0;
    r.sum = above + SUM_W'(row_sum);
    r.last = 1'b0;
    upper_sums[COL_W'(col_pos)] = r.sum;
    if (col_pos >= last_col) begin
      col_pos = 0;
      row_sum = '0;
      if (row_pos >= last_row) begin
        row_pos = 0;
        r.last = 1'b1;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
    return r;
  endfunction

  always @(posedge clk) begin : track
    area_result_t want;
    if (rst) begin
      width_reg = CFG_W'(MAX_COLS);
      height_reg = CFG_W'(MAX_ROWS);
      row_sum = '0;
      col_pos = 0;
      row_pos = 0;
      sums_due.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_FRAME_WIDTH) begin
          width_reg = cfg_data;
        end else begin
          height_reg = cfg_data;
        end
      end
      if (out_valid && !out_stall) begin
        if (sums_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got area_sum %0d frame_end %0b",
                   $time, area_sum, frame_end);
          fail_count++;
        end else begin
          want = sums_due.pop_front();
          if (area_sum !== want.sum) begin
            $display("%0t: area_sum mismatch, expected %0d, got %0d",
                     $time, want.sum, area_sum);
            fail_count++;
          end
          if (frame_end !== want.last) begin
            $display("%0t: frame_end mismatch, expected %0b, got %0b",
                     $time, want.last, frame_end);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        sums_due.insert(sums_due.size(), next_area(pixel));
      end
    end
    mismatches <= fail_count;
    outstanding <= $unsigned(sums_due.size());
  end

endmodule

### verif/tb_integral_image_stream.sv
`timescale 1ns / 100ps
module tb_integral_image_stream;
  import iis_pkg::*;

  localparam int unsigned RANDOM_PIXELS = 580;
  localparam int unsigned IDLE_PCT = 29;
  localparam int unsigned HOLD_AFTER = 40;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned QUIET_FROM = 100;
  localparam int unsigned QUIET_TO = 200;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam logic [PIX_W-1:0] FIRST_FRAME [6] = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd2, 8'd254};

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  logic             cfg_index = REG_FRAME_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [PIX_W-1:0] pixel = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [SUM_W-1:0] area_sum;
  logic             frame_end;
  int unsigned      mismatches;
  int unsigned      outstanding;
  int unsigned      pixels_sent = 0;

  integral_image_stream dut (.*);

  integral_image_checker area_check (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [PIX_W-1:0] any_pixel();
    int unsigned pick;
    pick = $urandom_range(7);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return PIX_W'($urandom_range(255));
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] v);
    while (!(pixels_sent >= QUIET_FROM && pixels_sent < QUIET_TO) &&
           $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic wait_results_in();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h);
    wait_results_in();
    cfg_write <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data <= CFG_W'(w);
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data <= CFG_W'(h);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin : receiver
    int unsigned taken;
    int unsigned hold_left;
    bit          held;
    taken = 0;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) taken++;
      if (!held && taken >= HOLD_AFTER) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (taken >= QUIET_FROM && taken < QUIET_TO) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int unsigned w;
    int unsigned h;
    int unsigned base;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    set_frame(3, 2);
    foreach (FIRST_FRAME[i]) send_pixel(FIRST_FRAME[i]);
    set_frame(0, 0);
    send_pixel(8'd255);
    send_pixel(8'd7);
    set_frame(1, 3);
    repeat (3) send_pixel(any_pixel());
    set_frame(4, 3);
    repeat (6) send_pixel(any_pixel());
    // Shrinking both sizes mid-frame ends the row and the frame on the next pixel.
    set_frame(2, 2);
    send_pixel(8'd255);
    repeat (4) send_pixel(any_pixel());

    // A row of the widest random width writes every line store entry that a
    // later size change in mid-frame can reach.
    set_frame(64, 1);
    repeat (64) send_pixel(any_pixel());

    // Oversized sizes are held at the maximum, and shrinking to one pixel
    // ends the long row and the tall frame early.
    set_frame(2047, 2);
    repeat (120) send_pixel('1);
    set_frame(1, 1);
    send_pixel('1);
    set_frame(1, 2047);
    repeat (40) send_pixel('1);
    set_frame(1, 1);
    send_pixel(any_pixel());

    base = pixels_sent;
    while (pixels_sent - base < RANDOM_PIXELS) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(1, 12);
      h = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
      set_frame(w, h);
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(1, 20)) send_pixel(any_pixel());
        set_frame($urandom_range(64), $urandom_range(8));
        repeat ($urandom_range(20)) send_pixel(any_pixel());
        set_frame(1, 1);
        send_pixel(any_pixel());
      end else begin
        repeat ((w == 0 ? 1 : w) * (h == 0 ? 1 : h)) send_pixel(any_pixel());
      end
    end

    wait_results_in();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
